>>> sv/cbis_pkg.sv
// Shared types and constants of the centered bilinear image sampler.
package cbis_pkg;

  localparam int ExtW       = 9;
  localparam int ParamW     = 13;
  localparam int CfgIdxW    = 2;
  localparam int IdxW       = 9;
  localparam int FracW      = 8;
  localparam int PixW       = 16;
  localparam int OffW       = 18;
  localparam int ResW       = 32;
  localparam int WeightW    = 17;
  localparam int QueueDepth = 2;

  localparam int MaxRowsDef = 256;
  localparam int MaxColsDef = 256;

  localparam logic [CfgIdxW-1:0] RegRows = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCols = 2'd1;

  localparam logic ActLoad   = 1'b0;
  localparam logic ActSample = 1'b1;

  typedef struct packed {
    logic                   is_sample;
    logic                   in_area;
    logic                   wr_en;
    logic [IdxW-1:0]        row;
    logic [IdxW-1:0]        col;
    logic [FracW-1:0]       t;
    logic [FracW-1:0]       u;
    logic signed [PixW-1:0] value;
  } item_t;

endpackage

>>> sv/cbis_front.sv
// Front end: command accept, extent registers, position classification.
module cbis_front #(
  parameter int MAX_ROWS = cbis_pkg::MaxRowsDef,
  parameter int MAX_COLS = cbis_pkg::MaxColsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               action_i,
  input  logic [7:0]                         load_row_i,
  input  logic [7:0]                         load_col_i,
  input  logic signed [cbis_pkg::PixW-1:0]   load_value_i,
  input  logic signed [cbis_pkg::OffW-1:0]   x_offset_i,
  input  logic signed [cbis_pkg::OffW-1:0]   y_offset_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cbis_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [cbis_pkg::ExtW-1:0]          cfg_data_i,
  output logic                               push_o,
  output cbis_pkg::item_t                    item_o,
  input  logic                               queue_full_i
);

  localparam logic [cbis_pkg::ParamW-1:0] MaxRowsW = cbis_pkg::ParamW'(MAX_ROWS);
  localparam logic [cbis_pkg::ParamW-1:0] MaxColsW = cbis_pkg::ParamW'(MAX_COLS);
  localparam int RowsRst = (MAX_ROWS < 256) ? MAX_ROWS : 256;
  localparam int ColsRst = (MAX_COLS < 256) ? MAX_COLS : 256;

  logic [cbis_pkg::ExtW-1:0] rows_q, rows_d, cols_q, cols_d;
  logic                      vld_q, vld_d;
  cbis_pkg::item_t           item_q, item_d;
  logic                      accept;

  logic [cbis_pkg::ExtW-1:0] rows_m1, cols_m1;
  logic [16:0]               xspan, yspan;
  logic [18:0]               xa, ya;
  logic                      in_x, in_y, in_area;
  logic                      load_ok;
  logic [cbis_pkg::ExtW-1:0] cfg_clamped;
  logic [cbis_pkg::ParamW-1:0] cfg_wide;

  assign busy        = vld_q & queue_full_i;
  assign accept      = start & ~busy;
  assign cfg_ready_o = 1'b1;
  assign push_o      = vld_q;
  assign item_o      = item_q;

  always_comb begin
    cfg_wide    = cbis_pkg::ParamW'(cfg_data_i);
    cfg_clamped = cfg_data_i;
    if (cfg_data_i < cbis_pkg::ExtW'(2)) begin
      cfg_clamped = cbis_pkg::ExtW'(2);
    end
    rows_d = rows_q;
    cols_d = cols_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cbis_pkg::RegRows: begin
          rows_d = (cfg_wide > MaxRowsW) ? cbis_pkg::ExtW'(MAX_ROWS) : cfg_clamped;
        end
        cbis_pkg::RegCols: begin
          cols_d = (cfg_wide > MaxColsW) ? cbis_pkg::ExtW'(MAX_COLS) : cfg_clamped;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rows_m1 = rows_q - cbis_pkg::ExtW'(1);
    cols_m1 = cols_q - cbis_pkg::ExtW'(1);
    xspan   = {rows_m1, 8'b0};
    yspan   = {cols_m1, 8'b0};
    xa      = {x_offset_i[cbis_pkg::OffW-1], x_offset_i} + {3'b000, rows_m1, 7'b0};
    ya      = {y_offset_i[cbis_pkg::OffW-1], y_offset_i} + {3'b000, cols_m1, 7'b0};
    in_x    = ~xa[18] && (xa[17:0] < {1'b0, xspan});
    in_y    = ~ya[18] && (ya[17:0] < {1'b0, yspan});
    in_area = in_x & in_y;
    load_ok = (cbis_pkg::ParamW'(load_row_i) < MaxRowsW) &&
              (cbis_pkg::ParamW'(load_col_i) < MaxColsW);

    item_d = item_q;
    vld_d  = vld_q & queue_full_i;
    if (accept) begin
      vld_d            = 1'b1;
      item_d.is_sample = (action_i == cbis_pkg::ActSample);
      item_d.value     = load_value_i;
      if (action_i == cbis_pkg::ActLoad) begin
        item_d.in_area = 1'b0;
        item_d.wr_en   = load_ok;
        item_d.row     = cbis_pkg::IdxW'(load_row_i);
        item_d.col     = cbis_pkg::IdxW'(load_col_i);
        item_d.t       = '0;
        item_d.u       = '0;
      end else begin
        item_d.in_area = in_area;
        item_d.wr_en   = 1'b0;
        item_d.row     = in_area ? xa[16:8] : '0;
        item_d.col     = in_area ? ya[16:8] : '0;
        item_d.t       = xa[7:0];
        item_d.u       = ya[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= cbis_pkg::ExtW'(RowsRst);
      cols_q <= cbis_pkg::ExtW'(ColsRst);
      vld_q  <= 1'b0;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

>>> sv/cbis_queue.sv
// Short queue between the front end and the sampling back end.
module cbis_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cbis_pkg::item_t item_i,
  output logic            full_o,
  output logic            valid_o,
  output cbis_pkg::item_t item_o
);

  localparam int PtrW = (cbis_pkg::QueueDepth > 1) ? $clog2(cbis_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(cbis_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(cbis_pkg::QueueDepth - 1);

  cbis_pkg::item_t      slot_q [cbis_pkg::QueueDepth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 push, pop;

  assign full_o  = (cnt_q == CntW'(cbis_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_ptr_q];
  assign push    = push_i & ~full_o;
  assign pop     = valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> sv/cbis_back.sv
// Back end: four-bank pixel store, weight and product stages, blend sum.
module cbis_back #(
  parameter int MAX_ROWS = cbis_pkg::MaxRowsDef,
  parameter int MAX_COLS = cbis_pkg::MaxColsDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  cbis_pkg::item_t                        item_i,
  output logic                                   result_valid_o,
  output logic signed [cbis_pkg::ResW-1:0]       sample_value_o,
  output logic                                   inside_res_o
);

  localparam int RowAw     = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
  localparam int ColAw     = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
  localparam int HalfRowAw = (RowAw > 1) ? RowAw - 1 : 1;
  localparam int HalfColAw = (ColAw > 1) ? ColAw - 1 : 1;
  localparam int BankAw    = HalfRowAw + HalfColAw;
  localparam int BankDepth = 2 ** BankAw;
  localparam int ProdW     = cbis_pkg::WeightW + 1 + cbis_pkg::PixW;
  localparam int SumW      = ProdW + 2;

  logic [RowAw-1:0]     row_r, row_p1;
  logic [ColAw-1:0]     col_c, col_p1;
  logic [HalfRowAw-1:0] rd_row [2];
  logic [HalfColAw-1:0] rd_col [2];
  logic [BankAw-1:0]    wr_addr;

  logic signed [cbis_pkg::PixW-1:0] rd_q [2][2];

  logic [cbis_pkg::FracW:0]          tc, uc, tw, uw;
  logic [cbis_pkg::WeightW-1:0]      w_d [4];
  logic [cbis_pkg::WeightW-1:0]      w_q [4];
  logic                              s1_vld_q, s1_inside_q, s1_xp_q, s1_yp_q;

  logic signed [cbis_pkg::PixW-1:0]  corner [4];
  logic signed [ProdW-1:0]           p_q [4];
  logic                              s2_vld_q, s2_inside_q;

  logic signed [SumW-1:0]            sum;
  logic                              res_vld_q;
  logic signed [cbis_pkg::ResW-1:0]  res_val_q;
  logic                              res_in_q;

  assign row_r   = RowAw'(item_i.row);
  assign col_c   = ColAw'(item_i.col);
  assign row_p1  = row_r + RowAw'(1);
  assign col_p1  = col_c + ColAw'(1);
  assign rd_row[0] = HalfRowAw'(row_p1 >> 1);
  assign rd_row[1] = HalfRowAw'(row_r >> 1);
  assign rd_col[0] = HalfColAw'(col_p1 >> 1);
  assign rd_col[1] = HalfColAw'(col_c >> 1);
  assign wr_addr = {HalfRowAw'(row_r >> 1), HalfColAw'(col_c >> 1)};

  for (genvar gr = 0; gr < 2; gr++) begin : g_row
    for (genvar gc = 0; gc < 2; gc++) begin : g_col
      logic [cbis_pkg::PixW-1:0] mem [BankDepth];
      logic                      we;
      assign we = valid_i & item_i.wr_en & (row_r[0] == 1'(gr)) & (col_c[0] == 1'(gc));
      always_ff @(posedge clk_i) begin
        if (we) begin
          mem[wr_addr] <= item_i.value;
        end
        rd_q[gr][gc] <= $signed(mem[{rd_row[gr], rd_col[gc]}]);
      end
    end
  end

  always_comb begin
    tw     = {1'b0, item_i.t};
    uw     = {1'b0, item_i.u};
    tc     = 9'd256 - tw;
    uc     = 9'd256 - uw;
    w_d[0] = cbis_pkg::WeightW'(tc) * cbis_pkg::WeightW'(uc);
    w_d[1] = cbis_pkg::WeightW'(tw) * cbis_pkg::WeightW'(uc);
    w_d[2] = cbis_pkg::WeightW'(tw) * cbis_pkg::WeightW'(uw);
    w_d[3] = cbis_pkg::WeightW'(tc) * cbis_pkg::WeightW'(uw);
  end

  always_comb begin
    corner[0] = rd_q[s1_xp_q][s1_yp_q];
    corner[1] = rd_q[~s1_xp_q][s1_yp_q];
    corner[2] = rd_q[~s1_xp_q][~s1_yp_q];
    corner[3] = rd_q[s1_xp_q][~s1_yp_q];
  end

  assign sum = SumW'(p_q[0]) + SumW'(p_q[1]) + SumW'(p_q[2]) + SumW'(p_q[3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= valid_i & item_i.is_sample;
      s2_vld_q  <= s1_vld_q;
      res_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_inside_q <= item_i.in_area;
    s1_xp_q     <= row_r[0];
    s1_yp_q     <= col_c[0];
    for (int i = 0; i < 4; i++) begin
      w_q[i] <= w_d[i];
      p_q[i] <= $signed({1'b0, w_q[i]}) * corner[i];
    end
    s2_inside_q <= s1_inside_q;
    res_in_q    <= s2_inside_q;
    res_val_q   <= s2_inside_q ? cbis_pkg::ResW'(sum) : '0;
  end

  assign result_valid_o = res_vld_q;
  assign sample_value_o = res_val_q;
  assign inside_res_o   = res_in_q;

endmodule

>>> sv/centered_bilinear_image_sampler.sv
// Top level of the centered bilinear image sampler.
// A sample passes the front register, the queue, the banked store read, the product stage
// and the sum register before its result strobe rises.
// Throughput: one command per cycle; four store banks give all corners in one read.
// busy rises only if the queue fills; results cannot be held off by the receiver.
// Reset clears control state and sets each extent to its maximum, capped at 256; pixels stay undefined.
module centered_bilinear_image_sampler #(
  parameter int MAX_ROWS = cbis_pkg::MaxRowsDef,
  parameter int MAX_COLS = cbis_pkg::MaxColsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               action_i,
  input  logic [7:0]                         load_row_i,
  input  logic [7:0]                         load_col_i,
  input  logic signed [cbis_pkg::PixW-1:0]   load_value_i,
  input  logic signed [cbis_pkg::OffW-1:0]   x_offset_i,
  input  logic signed [cbis_pkg::OffW-1:0]   y_offset_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cbis_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [cbis_pkg::ExtW-1:0]          cfg_data_i,
  output logic                               result_valid_o,
  output logic signed [cbis_pkg::ResW-1:0]   sample_value_o,
  output logic                               inside_res_o
);

  logic            push, queue_full, queue_valid;
  cbis_pkg::item_t front_item, queue_item;

  cbis_front #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .load_row_i   (load_row_i),
    .load_col_i   (load_col_i),
    .load_value_i (load_value_i),
    .x_offset_i   (x_offset_i),
    .y_offset_i   (y_offset_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push_o       (push),
    .item_o       (front_item),
    .queue_full_i (queue_full)
  );

  cbis_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  cbis_back #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (queue_valid),
    .item_i         (queue_item),
    .result_valid_o (result_valid_o),
    .sample_value_o (sample_value_o),
    .inside_res_o   (inside_res_o)
  );

endmodule

>>> dv/centered_bilinear_image_sampler_tb.sv
// Testbench for the centered bilinear image sampler: directed and random loads and samples, and extent writes.
`timescale 1ns / 100ps

module centered_bilinear_image_sampler_tb;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 8;
  localparam int MixItems      = 70;
  localparam int NumPhases     = 10;
  localparam int WindowMax     = 8;

  localparam logic [cbis_pkg::CfgIdxW-1:0] RegSpare = 2'd2;
  localparam logic signed [cbis_pkg::OffW-1:0] OffMin = {1'b1, {(cbis_pkg::OffW-1){1'b0}}};

  localparam int RowsSetting [NumPhases] = '{2, 0, 3, 16, 511, 256, 2, 9, 1, 257};
  localparam int ColsSetting [NumPhases] = '{2, 1, 17, 5, 300, 2, 256, 9, 200, 40};
  localparam int IdlePct [4] = '{0, 49, 0, 28};

  typedef struct {
    logic signed [cbis_pkg::ResW-1:0] value;
    logic                             in_area;
  } sample_t;

  class blend_scoreboard;
    logic signed [cbis_pkg::PixW-1:0] image [cbis_pkg::MaxRowsDef*cbis_pkg::MaxColsDef];
    int unsigned                      rows_ext;
    int unsigned                      cols_ext;
    sample_t                          pending_samples [$];
    int unsigned                      errors;

    function new();
      foreach (image[i]) image[i] = '0;
      rows_ext = cbis_pkg::MaxRowsDef;
      cols_ext = cbis_pkg::MaxColsDef;
      errors   = 0;
    endfunction

    function int unsigned clamp_extent(logic [cbis_pkg::ExtW-1:0] d, int unsigned maxv);
      if (d < 2) return 2;
      if (d > maxv) return maxv;
      return d;
    endfunction

    function void write_register(logic [cbis_pkg::CfgIdxW-1:0] idx,
                                 logic [cbis_pkg::ExtW-1:0] d);
      if (idx == cbis_pkg::RegRows) rows_ext = clamp_extent(d, cbis_pkg::MaxRowsDef);
      else if (idx == cbis_pkg::RegCols) cols_ext = clamp_extent(d, cbis_pkg::MaxColsDef);
    endfunction

    function longint pixel_at(int r, int c);
      return longint'(image[r*cbis_pkg::MaxColsDef + c]);
    endfunction

    function sample_t predict_blend(logic signed [cbis_pkg::OffW-1:0] xo,
                                    logic signed [cbis_pkg::OffW-1:0] yo);
      int      xspan;
      int      yspan;
      int      xa;
      int      ya;
      int      xl;
      int      yl;
      int      t;
      int      u;
      longint  acc;
      sample_t s;
      xspan = (int'(rows_ext) - 1) * 256;
      yspan = (int'(cols_ext) - 1) * 256;
      xa = int'(xo) + xspan / 2;
      ya = int'(yo) + yspan / 2;
      if (xa < 0 || ya < 0 || xa >= xspan || ya >= yspan) begin
        s.value   = '0;
        s.in_area = 1'b0;
        return s;
      end
      xl = xa / 256;
      yl = ya / 256;
      t  = xa % 256;
      u  = ya % 256;
      acc = longint'((256 - t) * (256 - u)) * pixel_at(xl, yl)
          + longint'(t * (256 - u)) * pixel_at(xl + 1, yl)
          + longint'(t * u) * pixel_at(xl + 1, yl + 1)
          + longint'((256 - t) * u) * pixel_at(xl, yl + 1);
      s.value   = acc[cbis_pkg::ResW-1:0];
      s.in_area = 1'b1;
      return s;
    endfunction

    function void note_command(logic act, logic [7:0] r, logic [7:0] c,
                               logic signed [cbis_pkg::PixW-1:0] v,
                               logic signed [cbis_pkg::OffW-1:0] xo,
                               logic signed [cbis_pkg::OffW-1:0] yo);
      if (act == cbis_pkg::ActLoad) image[{r, c}] = v;
      else pending_samples.push_back(predict_blend(xo, yo));
    endfunction

    function void check_result(logic signed [cbis_pkg::ResW-1:0] v, logic in);
      sample_t s;
      if (pending_samples.size() == 0) begin
        $error("unexpected result: sample_value %0d, inside_res %0d", v, in);
        errors++;
        return;
      end
      s = pending_samples.pop_front();
      if (in !== s.in_area) begin
        $error("inside_res: expected %0d, actual %0d", s.in_area, in);
        errors++;
      end
      if (v !== s.value) begin
        $error("sample_value: expected %0d, actual %0d", s.value, v);
        errors++;
      end
    endfunction
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             start;
  logic                             busy;
  logic                             action_i;
  logic [7:0]                       load_row_i;
  logic [7:0]                       load_col_i;
  logic signed [cbis_pkg::PixW-1:0] load_value_i;
  logic signed [cbis_pkg::OffW-1:0] x_offset_i;
  logic signed [cbis_pkg::OffW-1:0] y_offset_i;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [cbis_pkg::CfgIdxW-1:0]     cfg_index_i;
  logic [cbis_pkg::ExtW-1:0]        cfg_data_i;
  logic                             result_valid_o;
  logic signed [cbis_pkg::ResW-1:0] sample_value_o;
  logic                             inside_res_o;

  blend_scoreboard sb = new();
  bit              pixel_written [cbis_pkg::MaxRowsDef*cbis_pkg::MaxColsDef];
  int              idle_pct;
  int              quiet_cycles;
  int              win_r0;
  int              win_nr;
  int              win_c0;
  int              win_nc;

  centered_bilinear_image_sampler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .load_row_i     (load_row_i),
    .load_col_i     (load_col_i),
    .load_value_i   (load_value_i),
    .x_offset_i     (x_offset_i),
    .y_offset_i     (y_offset_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .sample_value_o (sample_value_o),
    .inside_res_o   (inside_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(sample_value_o, inside_res_o);
      if (start && !busy) begin
        sb.note_command(action_i, load_row_i, load_col_i, load_value_i, x_offset_i, y_offset_i);
      end
      if (cfg_valid_i && cfg_ready_o) sb.write_register(cfg_index_i, cfg_data_i);
      if (result_valid_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic bit corners_ready(logic signed [cbis_pkg::OffW-1:0] xo,
                                       logic signed [cbis_pkg::OffW-1:0] yo);
    int xspan;
    int yspan;
    int xa;
    int ya;
    int xl;
    int yl;
    xspan = (int'(sb.rows_ext) - 1) * 256;
    yspan = (int'(sb.cols_ext) - 1) * 256;
    xa = int'(xo) + xspan / 2;
    ya = int'(yo) + yspan / 2;
    if (xa < 0 || ya < 0 || xa >= xspan || ya >= yspan) return 1'b1;
    xl = xa / 256;
    yl = ya / 256;
    return pixel_written[xl*cbis_pkg::MaxColsDef + yl] &&
           pixel_written[(xl+1)*cbis_pkg::MaxColsDef + yl] &&
           pixel_written[xl*cbis_pkg::MaxColsDef + yl + 1] &&
           pixel_written[(xl+1)*cbis_pkg::MaxColsDef + yl + 1];
  endfunction

  function automatic int edge_offset(int unsigned ext);
    int span;
    int pos;
    span = (int'(ext) - 1) * 256;
    case ($urandom_range(4))
      0: pos = -1;
      1: pos = 0;
      2: pos = span - 1;
      3: pos = span;
      default: pos = int'($urandom_range(span - 1));
    endcase
    return pos - span / 2;
  endfunction

  function automatic int window_offset(int lo, int n, int unsigned ext);
    int span;
    span = (int'(ext) - 1) * 256;
    return int'($urandom_range(lo, lo + n - 2)) * 256 + int'($urandom_range(255)) - span / 2;
  endfunction

  task automatic issue_command(input logic act, input logic [7:0] r, input logic [7:0] c,
                               input logic signed [cbis_pkg::PixW-1:0] v,
                               input logic signed [cbis_pkg::OffW-1:0] xo,
                               input logic signed [cbis_pkg::OffW-1:0] yo);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    action_i     <= act;
    load_row_i   <= r;
    load_col_i   <= c;
    load_value_i <= v;
    x_offset_i   <= xo;
    y_offset_i   <= yo;
    start        <= 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic issue_load(input logic [7:0] r, input logic [7:0] c,
                            input logic signed [cbis_pkg::PixW-1:0] v);
    pixel_written[{r, c}] = 1'b1;
    issue_command(cbis_pkg::ActLoad, r, c, v,
                  cbis_pkg::OffW'($urandom), cbis_pkg::OffW'($urandom));
  endtask

  task automatic issue_sample(input logic signed [cbis_pkg::OffW-1:0] xo,
                              input logic signed [cbis_pkg::OffW-1:0] yo);
    issue_command(cbis_pkg::ActSample, 8'($urandom), 8'($urandom),
                  cbis_pkg::PixW'($urandom), xo, yo);
  endtask

  task automatic write_register(input logic [cbis_pkg::CfgIdxW-1:0] idx,
                                input logic [cbis_pkg::ExtW-1:0] d);
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.pending_samples.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin
    logic signed [cbis_pkg::OffW-1:0] xo;
    logic signed [cbis_pkg::OffW-1:0] yo;
    int                               sel;
    rst_ni       = 1'b0;
    start        = 1'b0;
    action_i     = cbis_pkg::ActLoad;
    load_row_i   = '0;
    load_col_i   = '0;
    load_value_i = '0;
    x_offset_i   = '0;
    y_offset_i   = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = cbis_pkg::RegRows;
    cfg_data_i   = '0;
    idle_pct     = 0;
    quiet_cycles = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 127; r <= 129; r++) begin
      for (int c = 127; c <= 129; c++) begin
        if (r == 127 && c == 127) issue_load(8'(r), 8'(c), 16'sh7fff);
        else if (r == 128 && c == 128) issue_load(8'(r), 8'(c), 16'sh8000);
        else issue_load(8'(r), 8'(c), cbis_pkg::PixW'($urandom));
      end
    end
    for (int r = 0; r < 2; r++) begin
      for (int c = 0; c < 2; c++) issue_load(8'(r), 8'(c), cbis_pkg::PixW'($urandom));
    end
    for (int r = 254; r < 256; r++) begin
      for (int c = 254; c < 256; c++) issue_load(8'(r), 8'(c), cbis_pkg::PixW'($urandom));
    end
    issue_sample(cbis_pkg::OffW'(0), cbis_pkg::OffW'(0));
    issue_sample(cbis_pkg::OffW'(-128), cbis_pkg::OffW'(-128));
    issue_sample(cbis_pkg::OffW'(128), cbis_pkg::OffW'(128));
    issue_sample(cbis_pkg::OffW'(-1), cbis_pkg::OffW'(-1));
    issue_sample(cbis_pkg::OffW'(-32640), cbis_pkg::OffW'(-32640));
    issue_sample(cbis_pkg::OffW'(-32641), cbis_pkg::OffW'(0));
    issue_sample(cbis_pkg::OffW'(32639), cbis_pkg::OffW'(32639));
    issue_sample(cbis_pkg::OffW'(32640), cbis_pkg::OffW'(0));
    issue_sample(cbis_pkg::OffW'(131071), cbis_pkg::OffW'(-131072));
    issue_sample(cbis_pkg::OffW'(-131072), cbis_pkg::OffW'(131071));
    settle();

    for (int phase = 0; phase < NumPhases; phase++) begin
      idle_pct = IdlePct[phase % 4];
      write_register(cbis_pkg::RegRows, cbis_pkg::ExtW'(RowsSetting[phase]));
      write_register(cbis_pkg::RegCols, cbis_pkg::ExtW'(ColsSetting[phase]));
      if (phase == 3) write_register(RegSpare, cbis_pkg::ExtW'($urandom));
      cfg_valid_i <= 1'b0;
      @(negedge clk_i);

      win_nr = (sb.rows_ext < WindowMax) ? int'(sb.rows_ext) : WindowMax;
      win_nc = (sb.cols_ext < WindowMax) ? int'(sb.cols_ext) : WindowMax;
      win_r0 = int'($urandom_range(sb.rows_ext - win_nr));
      win_c0 = int'($urandom_range(sb.cols_ext - win_nc));
      for (int r = win_r0; r < win_r0 + win_nr; r++) begin
        for (int c = win_c0; c < win_c0 + win_nc; c++) begin
          issue_load(8'(r), 8'(c), cbis_pkg::PixW'($urandom));
        end
      end

      repeat (MixItems) begin
        sel = int'($urandom_range(99));
        if (sel < 30) begin
          issue_load(8'($urandom), 8'($urandom), cbis_pkg::PixW'($urandom));
        end else if (sel < 80) begin
          xo = cbis_pkg::OffW'(window_offset(win_r0, win_nr, sb.rows_ext));
          yo = cbis_pkg::OffW'(window_offset(win_c0, win_nc, sb.cols_ext));
          issue_sample(xo, yo);
        end else begin
          if ($urandom_range(1)) begin
            xo = cbis_pkg::OffW'($urandom);
            yo = cbis_pkg::OffW'($urandom);
          end else begin
            xo = cbis_pkg::OffW'(edge_offset(sb.rows_ext));
            yo = cbis_pkg::OffW'(edge_offset(sb.cols_ext));
          end
          // force outside when a corner pixel is still unwritten
          if (!corners_ready(xo, yo)) xo = OffMin;
          issue_sample(xo, yo);
        end
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending_samples.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> centered_bilinear_image_sampler.f
sv/cbis_pkg.sv
sv/cbis_front.sv
sv/cbis_queue.sv
sv/cbis_back.sv
sv/centered_bilinear_image_sampler.sv
dv/centered_bilinear_image_sampler_tb.sv
